// ----- rtl/riscv_relocation_patcher_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the relocation patcher core
// ---------------------------------------------------------------------------
`ifndef RISCV_RELOCATION_PATCHER_CORE_DEFINES_SVH
`define RISCV_RELOCATION_PATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RRP_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rrp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RRP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rrp: next-cycle check failed");

`endif

// ----- rtl/rrp_pkg.sv -----
// ---------------------------------------------------------------------------
// rrp_pkg
// Relocation codes, operation classes and stage records of the patcher.
// ---------------------------------------------------------------------------
package rrp_pkg;

   // psABI relocation type codes
   localparam logic [7:0] RELOC_NONE         = 8'd0;
   localparam logic [7:0] RELOC_32           = 8'd1;
   localparam logic [7:0] RELOC_64           = 8'd2;
   localparam logic [7:0] RELOC_BRANCH       = 8'd16;
   localparam logic [7:0] RELOC_JAL          = 8'd17;
   localparam logic [7:0] RELOC_CALL         = 8'd18;
   localparam logic [7:0] RELOC_PCREL_HI20   = 8'd23;
   localparam logic [7:0] RELOC_PCREL_LO12_I = 8'd24;
   localparam logic [7:0] RELOC_PCREL_LO12_S = 8'd25;
   localparam logic [7:0] RELOC_HI20         = 8'd26;
   localparam logic [7:0] RELOC_LO12_I       = 8'd27;
   localparam logic [7:0] RELOC_LO12_S       = 8'd28;
   localparam logic [7:0] RELOC_ADD8         = 8'd33;
   localparam logic [7:0] RELOC_ADD16        = 8'd34;
   localparam logic [7:0] RELOC_ADD32        = 8'd35;
   localparam logic [7:0] RELOC_ADD64        = 8'd36;
   localparam logic [7:0] RELOC_SUB8         = 8'd37;
   localparam logic [7:0] RELOC_SUB16        = 8'd38;
   localparam logic [7:0] RELOC_SUB32        = 8'd39;
   localparam logic [7:0] RELOC_SUB64        = 8'd40;
   localparam logic [7:0] RELOC_ALIGN        = 8'd43;
   localparam logic [7:0] RELOC_RVC_BRANCH   = 8'd44;
   localparam logic [7:0] RELOC_RVC_JUMP     = 8'd45;
   localparam logic [7:0] RELOC_RVC_LUI      = 8'd46;
   localparam logic [7:0] RELOC_RELAX        = 8'd51;
   localparam logic [7:0] RELOC_SUB6         = 8'd52;
   localparam logic [7:0] RELOC_SET6         = 8'd53;
   localparam logic [7:0] RELOC_SET8         = 8'd54;
   localparam logic [7:0] RELOC_SET16        = 8'd55;
   localparam logic [7:0] RELOC_SET32        = 8'd56;
   localparam logic [7:0] RELOC_32_PCREL     = 8'd57;

   localparam logic [63:0] LUI_ROUND = 64'h800;

   typedef enum logic [4:0] {
      OP_PASS,
      OP_PUT32,
      OP_ABS64,
      OP_RVC_BRANCH,
      OP_RVC_JUMP,
      OP_RVC_LUI,
      OP_JAL,
      OP_BRANCH,
      OP_CALL,
      OP_HI20,
      OP_LO12_I,
      OP_LO12_S,
      OP_ADD8,
      OP_ADD16,
      OP_ADD32,
      OP_ADD64,
      OP_SUB6,
      OP_SUB8,
      OP_SUB16,
      OP_SUB32,
      OP_SUB64,
      OP_SET6,
      OP_SET8,
      OP_SET16,
      OP_UNSUP
   } op_type;

   typedef enum logic [1:0] {
      KIND_ABS      = 2'd0,
      KIND_PCREL    = 2'd1,
      KIND_PCINDIR  = 2'd2,
      KIND_HINT     = 2'd3
   } kind_type;

   // after decode
   typedef struct packed {
      op_type      op;
      kind_type    kind;
      logic [63:0] val;
      logic [63:0] site;
   } dec_type;

   // after arithmetic
   typedef struct packed {
      op_type      op;
      kind_type    kind;
      logic [63:0] val;
      logic [63:0] site;
      logic [31:0] upper;   // (val + 0x800) >> 12, low 32 bits
      logic [63:0] sum;
      logic [63:0] diff;
      logic        rng;
      logic        aln;
   } ari_type;

   // result record
   typedef struct packed {
      logic [63:0] patched;
      logic        rng;
      logic        aln;
      logic        uns;
      kind_type    kind;
   } res_type;

endpackage

// ----- rtl/rrp_decode.sv -----
// ---------------------------------------------------------------------------
// rrp_decode
// First stage: maps the relocation code to an operation class and kind.
// ---------------------------------------------------------------------------
module rrp_decode (
   input  logic             clock,
   input  logic             load,
   input  logic [7:0]       func,
   input  logic [63:0]      reloc_value,
   input  logic [63:0]      site_bytes,
   output rrp_pkg::dec_type dec_ff
);

   rrp_pkg::dec_type dec_in;

   always_comb begin
      dec_in.val  = reloc_value;
      dec_in.site = site_bytes;
      unique case (func)
         rrp_pkg::RELOC_NONE, rrp_pkg::RELOC_ALIGN, rrp_pkg::RELOC_RELAX:
            dec_in.op = rrp_pkg::OP_PASS;
         rrp_pkg::RELOC_32, rrp_pkg::RELOC_SET32, rrp_pkg::RELOC_32_PCREL:
            dec_in.op = rrp_pkg::OP_PUT32;
         rrp_pkg::RELOC_64:           dec_in.op = rrp_pkg::OP_ABS64;
         rrp_pkg::RELOC_RVC_BRANCH:   dec_in.op = rrp_pkg::OP_RVC_BRANCH;
         rrp_pkg::RELOC_RVC_JUMP:     dec_in.op = rrp_pkg::OP_RVC_JUMP;
         rrp_pkg::RELOC_RVC_LUI:      dec_in.op = rrp_pkg::OP_RVC_LUI;
         rrp_pkg::RELOC_JAL:          dec_in.op = rrp_pkg::OP_JAL;
         rrp_pkg::RELOC_BRANCH:       dec_in.op = rrp_pkg::OP_BRANCH;
         rrp_pkg::RELOC_CALL:         dec_in.op = rrp_pkg::OP_CALL;
         rrp_pkg::RELOC_PCREL_HI20, rrp_pkg::RELOC_HI20:
            dec_in.op = rrp_pkg::OP_HI20;
         rrp_pkg::RELOC_PCREL_LO12_I, rrp_pkg::RELOC_LO12_I:
            dec_in.op = rrp_pkg::OP_LO12_I;
         rrp_pkg::RELOC_PCREL_LO12_S, rrp_pkg::RELOC_LO12_S:
            dec_in.op = rrp_pkg::OP_LO12_S;
         rrp_pkg::RELOC_ADD8:         dec_in.op = rrp_pkg::OP_ADD8;
         rrp_pkg::RELOC_ADD16:        dec_in.op = rrp_pkg::OP_ADD16;
         rrp_pkg::RELOC_ADD32:        dec_in.op = rrp_pkg::OP_ADD32;
         rrp_pkg::RELOC_ADD64:        dec_in.op = rrp_pkg::OP_ADD64;
         rrp_pkg::RELOC_SUB6:         dec_in.op = rrp_pkg::OP_SUB6;
         rrp_pkg::RELOC_SUB8:         dec_in.op = rrp_pkg::OP_SUB8;
         rrp_pkg::RELOC_SUB16:        dec_in.op = rrp_pkg::OP_SUB16;
         rrp_pkg::RELOC_SUB32:        dec_in.op = rrp_pkg::OP_SUB32;
         rrp_pkg::RELOC_SUB64:        dec_in.op = rrp_pkg::OP_SUB64;
         rrp_pkg::RELOC_SET6:         dec_in.op = rrp_pkg::OP_SET6;
         rrp_pkg::RELOC_SET8:         dec_in.op = rrp_pkg::OP_SET8;
         rrp_pkg::RELOC_SET16:        dec_in.op = rrp_pkg::OP_SET16;
         default:                     dec_in.op = rrp_pkg::OP_UNSUP;
      endcase

      unique case (func)
         rrp_pkg::RELOC_BRANCH, rrp_pkg::RELOC_JAL, rrp_pkg::RELOC_CALL,
         rrp_pkg::RELOC_PCREL_HI20, rrp_pkg::RELOC_RVC_BRANCH,
         rrp_pkg::RELOC_RVC_JUMP, rrp_pkg::RELOC_32_PCREL:
            dec_in.kind = rrp_pkg::KIND_PCREL;
         rrp_pkg::RELOC_PCREL_LO12_I, rrp_pkg::RELOC_PCREL_LO12_S:
            dec_in.kind = rrp_pkg::KIND_PCINDIR;
         rrp_pkg::RELOC_ALIGN, rrp_pkg::RELOC_RELAX:
            dec_in.kind = rrp_pkg::KIND_HINT;
         default:
            dec_in.kind = rrp_pkg::KIND_ABS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dec_ff <= dec_in;
      end
   end

endmodule

// ----- rtl/rrp_arith.sv -----
// ---------------------------------------------------------------------------
// rrp_arith
// Second stage: 64-bit add/subtract, lui rounding and range/alignment flags.
// ---------------------------------------------------------------------------
module rrp_arith (
   input  logic             clock,
   input  logic             load,
   input  rrp_pkg::dec_type dec,
   output rrp_pkg::ari_type ari_ff
);

   rrp_pkg::ari_type ari_in;
   logic [63:0]      rounded;
   logic             fit9, fit12, fit13, fit21, fit32;

   // a value fits n signed bits when bits 63..n-1 are all equal
   assign fit9  = (&dec.val[63:8])  | ~(|dec.val[63:8]);
   assign fit12 = (&dec.val[63:11]) | ~(|dec.val[63:11]);
   assign fit13 = (&dec.val[63:12]) | ~(|dec.val[63:12]);
   assign fit21 = (&dec.val[63:20]) | ~(|dec.val[63:20]);
   assign fit32 = (&dec.val[63:31]) | ~(|dec.val[63:31]);

   assign rounded = dec.val + rrp_pkg::LUI_ROUND;

   always_comb begin
      ari_in.op    = dec.op;
      ari_in.kind  = dec.kind;
      ari_in.val   = dec.val;
      ari_in.site  = dec.site;
      ari_in.upper = rounded[43:12];
      ari_in.sum   = dec.site + dec.val;
      ari_in.diff  = dec.site - dec.val;
      ari_in.rng   = 1'b0;
      ari_in.aln   = 1'b0;
      unique case (dec.op)
         rrp_pkg::OP_RVC_BRANCH: begin
            ari_in.rng = ~fit9;
            ari_in.aln = dec.val[0];
         end
         rrp_pkg::OP_RVC_JUMP: begin
            ari_in.rng = ~fit12;
            ari_in.aln = dec.val[0];
         end
         rrp_pkg::OP_BRANCH: begin
            ari_in.rng = ~fit13;
            ari_in.aln = dec.val[0];
         end
         rrp_pkg::OP_JAL: begin
            ari_in.rng = ~fit21;
            ari_in.aln = dec.val[0];
         end
         // rounded upper value must lie in 0..63
         rrp_pkg::OP_RVC_LUI: ari_in.rng = |rounded[43:18];
         rrp_pkg::OP_CALL, rrp_pkg::OP_HI20, rrp_pkg::OP_LO12_I,
         rrp_pkg::OP_LO12_S:  ari_in.rng = ~fit32;
         default: begin
            ari_in.rng = 1'b0;
            ari_in.aln = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ari_ff <= ari_in;
      end
   end

endmodule

// ----- rtl/rrp_assemble.sv -----
// ---------------------------------------------------------------------------
// rrp_assemble
// Third stage: scatters immediate bits into the instruction fields and
// selects the patched bytes; holds the result register.
// ---------------------------------------------------------------------------
module rrp_assemble (
   input  logic             clock,
   input  logic             load,
   input  rrp_pkg::ari_type ari,
   output rrp_pkg::res_type res_ff
);

   rrp_pkg::res_type res_in;
   logic [63:0]      s;
   logic [63:0]      v;
   logic [15:0]      h;
   logic [31:0]      w;
   logic [31:0]      hi_w;
   logic [15:0]      cb_x, cj_x, lui_x;
   logic [31:0]      jal_x, br_x, hi20_x, lo12i_x, lo12s_x, call_lo_x;

   assign s    = ari.site;
   assign v    = ari.val;
   assign h    = s[15:0];
   assign w    = s[31:0];
   assign hi_w = s[63:32];

   assign cb_x  = {h[15:13], v[8], v[4:3], h[9:7], v[7:6], v[2:1], v[5], h[1:0]};
   assign cj_x  = {h[15:13], v[11], v[4], v[9:8], v[10], v[6], v[7], v[3:1], v[5],
                   h[1:0]};
   // zero upper value turns the instruction into c.li rd, 0
   assign lui_x = (ari.upper == 32'd0) ? {3'b010, 1'b0, h[11:7], 5'd0, h[1:0]}
                                       : {h[15:13], ari.upper[5], h[11:7],
                                          ari.upper[4:0], h[1:0]};
   assign jal_x     = {v[20], v[10:1], v[11], v[19:12], w[11:0]};
   assign br_x      = {v[12], v[10:5], w[24:12], v[4:1], v[11], w[6:0]};
   // low 12 bits of (value - upper part) equal the value's own low 12 bits
   assign hi20_x    = {ari.upper[19:0], w[11:0]};
   assign lo12i_x   = {v[11:0], w[19:0]};
   assign lo12s_x   = {v[11:5], w[24:12], v[4:0], w[6:0]};
   assign call_lo_x = {v[11:0], hi_w[19:0]};

   always_comb begin
      res_in.rng     = ari.rng;
      res_in.aln     = ari.aln;
      res_in.kind    = ari.kind;
      res_in.uns     = 1'b0;
      res_in.patched = s;
      unique case (ari.op)
         rrp_pkg::OP_PASS:       res_in.patched = s;
         rrp_pkg::OP_PUT32:      res_in.patched = {s[63:32], v[31:0]};
         rrp_pkg::OP_ABS64:      res_in.patched = v;
         rrp_pkg::OP_RVC_BRANCH: res_in.patched = {s[63:16], cb_x};
         rrp_pkg::OP_RVC_JUMP:   res_in.patched = {s[63:16], cj_x};
         rrp_pkg::OP_RVC_LUI:    res_in.patched = {s[63:16], lui_x};
         rrp_pkg::OP_JAL:        res_in.patched = {s[63:32], jal_x};
         rrp_pkg::OP_BRANCH:     res_in.patched = {s[63:32], br_x};
         rrp_pkg::OP_CALL:       res_in.patched = {call_lo_x, hi20_x};
         rrp_pkg::OP_HI20:       res_in.patched = {s[63:32], hi20_x};
         rrp_pkg::OP_LO12_I:     res_in.patched = {s[63:32], lo12i_x};
         rrp_pkg::OP_LO12_S:     res_in.patched = {s[63:32], lo12s_x};
         rrp_pkg::OP_ADD8:       res_in.patched = {s[63:8], ari.sum[7:0]};
         rrp_pkg::OP_ADD16:      res_in.patched = {s[63:16], ari.sum[15:0]};
         rrp_pkg::OP_ADD32:      res_in.patched = {s[63:32], ari.sum[31:0]};
         rrp_pkg::OP_ADD64:      res_in.patched = ari.sum;
         rrp_pkg::OP_SUB6:       res_in.patched = {s[63:6], ari.diff[5:0]};
         rrp_pkg::OP_SUB8:       res_in.patched = {s[63:8], ari.diff[7:0]};
         rrp_pkg::OP_SUB16:      res_in.patched = {s[63:16], ari.diff[15:0]};
         rrp_pkg::OP_SUB32:      res_in.patched = {s[63:32], ari.diff[31:0]};
         rrp_pkg::OP_SUB64:      res_in.patched = ari.diff;
         rrp_pkg::OP_SET6:       res_in.patched = {s[63:6], v[5:0]};
         rrp_pkg::OP_SET8:       res_in.patched = {s[63:8], v[7:0]};
         rrp_pkg::OP_SET16:      res_in.patched = {s[63:16], v[15:0]};
         rrp_pkg::OP_UNSUP: begin
            res_in.patched = s;
            res_in.uns     = 1'b1;
         end
         default:                res_in.patched = s;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

endmodule

// ----- rtl/riscv_relocation_patcher_core.sv -----
// ---------------------------------------------------------------------------
// riscv_relocation_patcher_core
// Applies one RISC-V ELF relocation per item to eight site bytes.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  func, reloc_value, site_bytes
//   rsp      out  rsp_valid / rsp_stall  patched_bytes, flags, value_kind
//
// Three register stages (decode, arithmetic, assemble); one item per cycle unless req_stall is high.
// An item passes the decode, arithmetic and result registers in order before rsp_valid rises.
// Each stage loads when it is empty or its successor loads, so bubbles close
// up while the output is stalled; req_stall rises only with all stages full.
// Synchronous reset clears the stage valid bits; nothing else is reset.
// ---------------------------------------------------------------------------
`include "riscv_relocation_patcher_core_defines.svh"

module riscv_relocation_patcher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_func,
   input  logic [63:0] req_reloc_value,
   input  logic [63:0] req_site_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_patched_bytes,
   output logic        rsp_range_error,
   output logic        rsp_align_error,
   output logic        rsp_unsupported,
   output logic [1:0]  rsp_value_kind
);

   logic             dec_vld_ff, ari_vld_ff, res_vld_ff;
   logic             dec_vld_in, ari_vld_in, res_vld_in;
   logic             dec_load, ari_load, res_load;
   rrp_pkg::dec_type dec_ff;
   rrp_pkg::ari_type ari_ff;
   rrp_pkg::res_type res_ff;

   assign res_load = ~res_vld_ff | ~rsp_stall;
   assign ari_load = ~ari_vld_ff | res_load;
   assign dec_load = ~dec_vld_ff | ari_load;

   assign dec_vld_in = dec_load ? req_valid  : dec_vld_ff;
   assign ari_vld_in = ari_load ? dec_vld_ff : ari_vld_ff;
   assign res_vld_in = res_load ? ari_vld_ff : res_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_vld_ff <= 1'b0;
         ari_vld_ff <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         dec_vld_ff <= dec_vld_in;
         ari_vld_ff <= ari_vld_in;
         res_vld_ff <= res_vld_in;
      end
   end

   rrp_decode u_decode (
      .clock       (clock),
      .load        (dec_load & req_valid),
      .func        (req_func),
      .reloc_value (req_reloc_value),
      .site_bytes  (req_site_bytes),
      .dec_ff      (dec_ff)
   );

   rrp_arith u_arith (
      .clock  (clock),
      .load   (ari_load & dec_vld_ff),
      .dec    (dec_ff),
      .ari_ff (ari_ff)
   );

   rrp_assemble u_assemble (
      .clock  (clock),
      .load   (res_load & ari_vld_ff),
      .ari    (ari_ff),
      .res_ff (res_ff)
   );

   assign req_stall         = ~dec_load;
   assign rsp_valid         = res_vld_ff;
   assign rsp_patched_bytes = res_ff.patched;
   assign rsp_range_error   = res_ff.rng;
   assign rsp_align_error   = res_ff.aln;
   assign rsp_unsupported   = res_ff.uns;
   assign rsp_value_kind    = res_ff.kind;

   // input is held off only when every stage is full and the output waits
   `RRP_ASSERT_IMPLY(a_stall_full, clock, reset, req_stall,
      dec_vld_ff && ari_vld_ff && res_vld_ff && rsp_stall)
   // a stalled, full tail keeps its middle item
   `RRP_ASSERT_NEXT(a_mid_hold, clock, reset, ari_vld_ff && res_vld_ff && rsp_stall,
      ari_vld_ff)
   // unsupported types never raise the check flags
   `RRP_ASSERT_IMPLY(a_uns_flags, clock, reset, rsp_valid && rsp_unsupported,
      !rsp_range_error && !rsp_align_error)

endmodule
